// ===== rtl/tmad_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the touch motion accumulator drain block
// no dependencies; used by tmad_track, tmad_axis and the top level

package tmad_pkg;

    typedef enum logic {
        MODE_TOUCH = 1'b0,
        MODE_READ  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MOTION_GAIN    = 2'd0,
        CFG_FAST_THRESHOLD = 2'd1,
        CFG_FAST_STEP      = 2'd2
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [3:0] GAIN_RESET      = 4'd2;
    localparam logic [7:0] THRESHOLD_RESET = 8'd10;
    localparam logic [3:0] FAST_STEP_RESET = 4'd2;

    localparam logic [7:0] COUNT_MAX  = 8'hff;
    localparam logic [7:0] SWITCH_ON  = 8'h80;
    localparam logic [7:0] SWITCH_OFF = 8'h00;

    // movement handed from the position tracker to the two axis counters
    typedef struct packed {
        logic              move;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
    } t_move;

    // gain and drain settings shared by both axes
    typedef struct packed {
        logic [3:0] gain;
        logic [7:0] threshold;
        logic [3:0] fast_step;
    } t_axis_cfg;

endpackage

// ===== rtl/tmad_in_if.sv =====
`timescale 1ns / 1ps
// input channel: touch samples and host reads with valid/ready handshake
// depends on nothing but carries plain logic fields

interface tmad_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       touch_start;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic       button_pressed;

    modport source (
        output valid, mode, touch_start, x_pos, y_pos, button_pressed,
        input  ready
    );
    modport sink (
        input  valid, mode, touch_start, x_pos, y_pos, button_pressed,
        output ready
    );
endinterface

// ===== rtl/tmad_out_if.sv =====
`timescale 1ns / 1ps
// output channel: drain steps and switch byte per host read
// depends on nothing but carries plain logic fields

interface tmad_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] right_step;
    logic [3:0] left_step;
    logic [3:0] down_step;
    logic [3:0] up_step;
    logic [7:0] switch_byte;

    modport source (
        output valid, right_step, left_step, down_step, up_step, switch_byte,
        input  ready
    );
    modport sink (
        input  valid, right_step, left_step, down_step, up_step, switch_byte,
        output ready
    );
endinterface

// ===== rtl/tmad_track.sv =====
`timescale 1ns / 1ps
// position tracker: touch-start arming, first-move skip, delta and button state
// depends on tmad_pkg

module tmad_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_touch_en,
    input  logic               i_touch_start,
    input  logic [7:0]         i_x_pos,
    input  logic [7:0]         i_y_pos,
    input  logic               i_button_pressed,
    output tmad_pkg::t_move    o_move,
    output logic               o_button_held
);

    logic [7:0] r_last_x, n_last_x;
    logic [7:0] r_last_y, n_last_y;
    logic       r_tracking, n_tracking;
    logic       r_skip, n_skip;
    logic       r_button, n_button;
    logic       w_moved;

    assign w_moved = (i_x_pos != r_last_x) || (i_y_pos != r_last_y);

    always_comb begin
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_tracking = r_tracking;
        n_skip     = r_skip;
        n_button   = r_button;
        o_move.move = 1'b0;
        o_move.dx   = $signed({1'b0, i_x_pos}) - $signed({1'b0, r_last_x});
        o_move.dy   = $signed({1'b0, i_y_pos}) - $signed({1'b0, r_last_y});
        if (i_touch_en) begin
            n_button = i_button_pressed;
            if (i_touch_start) begin
                // latch position; move stays low so nothing moves
                n_tracking = 1'b1;
                n_skip     = 1'b1;
                n_last_x   = i_x_pos;
                n_last_y   = i_y_pos;
            end else if (r_tracking && w_moved) begin
                if (r_skip) begin
                    n_skip = 1'b0;
                end else begin
                    o_move.move = 1'b1;
                end
                n_last_x = i_x_pos;
                n_last_y = i_y_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_tracking <= 1'b0;
            r_skip     <= 1'b0;
            r_button   <= 1'b0;
        end else begin
            r_last_x   <= n_last_x;
            r_last_y   <= n_last_y;
            r_tracking <= n_tracking;
            r_skip     <= n_skip;
            r_button   <= n_button;
        end
    end

    assign o_button_held = r_button;

endmodule

// ===== rtl/tmad_axis.sv =====
`timescale 1ns / 1ps
// one axis: plus/minus byte counters, gain accumulate with clamp, host drain
// depends on tmad_pkg

module tmad_axis (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tmad_pkg::t_axis_cfg   i_cfg,
    input  logic                  i_move_en,
    input  logic signed [8:0]     i_delta,
    input  logic                  i_read_en,
    output logic [3:0]            o_plus_step,
    output logic [3:0]            o_minus_step
);

    logic [7:0]         r_plus, n_plus;
    logic [7:0]         r_minus, n_minus;
    logic signed [13:0] w_prod;
    logic signed [13:0] w_total;
    logic [7:0]         w_plus_rest;
    logic [7:0]         w_minus_rest;

    // fast step above threshold, else one while nonzero, else nothing
    always_comb begin
        if (r_plus > i_cfg.threshold) begin
            o_plus_step = i_cfg.fast_step;
        end else if (r_plus != 8'd0) begin
            o_plus_step = 4'd1;
        end else begin
            o_plus_step = 4'd0;
        end
        if (r_minus > i_cfg.threshold) begin
            o_minus_step = i_cfg.fast_step;
        end else if (r_minus != 8'd0) begin
            o_minus_step = 4'd1;
        end else begin
            o_minus_step = 4'd0;
        end
        w_plus_rest  = (r_plus >= {4'd0, o_plus_step}) ?
                       (r_plus - {4'd0, o_plus_step}) : 8'd0;
        w_minus_rest = (r_minus >= {4'd0, o_minus_step}) ?
                       (r_minus - {4'd0, o_minus_step}) : 8'd0;
    end

    assign w_prod  = 14'(i_delta * $signed({1'b0, i_cfg.gain}));
    assign w_total = $signed({6'd0, r_plus}) - $signed({6'd0, r_minus}) + w_prod;

    always_comb begin
        n_plus  = r_plus;
        n_minus = r_minus;
        if (i_move_en) begin
            if (w_total <= -14'sd255) begin
                n_plus  = 8'd0;
                n_minus = tmad_pkg::COUNT_MAX;
            end else if (w_total <= 14'sd0) begin
                n_plus  = 8'd0;
                n_minus = 8'((-w_total));
            end else if (w_total <= 14'sd255) begin
                n_plus  = 8'(w_total);
                n_minus = 8'd0;
            end else begin
                n_plus  = tmad_pkg::COUNT_MAX;
                n_minus = 8'd0;
            end
        end else if (i_read_en) begin
            n_plus  = w_plus_rest;
            n_minus = w_minus_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus  <= '0;
            r_minus <= '0;
        end else begin
            r_plus  <= n_plus;
            r_minus <= n_minus;
        end
    end

    // the clamp and the drain never leave both directions nonzero
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_plus != 8'd0) && (r_minus != 8'd0)))
        else $error("both direction counters nonzero");

    // a move and a read never land on the same item
    a_excl_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_move_en && i_read_en))
        else $error("move and read in the same cycle");

    // a read of an empty counter leaves it empty
    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_read_en && (r_plus == 8'd0)) |=> (r_plus == 8'd0))
        else $error("read raised an empty counter");

endmodule

// ===== rtl/touch_motion_accumulator_drain.sv =====
`timescale 1ns / 1ps
// top level of the touch motion accumulator with host drain
// depends on tmad_pkg, tmad_in_if, tmad_out_if, tmad_track, tmad_axis
//
// usage
// - i_in carries touch samples (mode 0) and host reads (mode 1); one
//   transaction per clock when valid and ready are both high
// - a touch sample produces no output; it updates the latched position,
//   the button state and, once tracking is armed and past its first move,
//   the four motion byte counters
// - each host read produces exactly one o_out transaction with the four
//   drain steps and the switch byte, then lowers the counters
// - an accepted transaction is first held in the input register; its state
//   update and (for a read) the output register load happen as it leaves
//   that register, which a read can only do once the output slot is free
// - throughput: one transaction per cycle unless a read stalls on o_out, as
//   the counters take each update as it leaves the input register
// - when o_out stalls, a pending read waits in the input register and
//   i_in.ready drops only once that register holds an unissued read;
//   touch samples keep flowing past a full output register
// - configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx;
//   write only while idle (the block does not enforce this); unknown indexes are dropped
// - synchronous active-low reset clears all counters, tracking, the button
//   state, both valid flags and loads the default configuration

module touch_motion_accumulator_drain (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [tmad_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tmad_in_if.sink                            i_in,
    tmad_out_if.source                         o_out
);

    // configuration registers
    logic [3:0] r_gain;
    logic [7:0] r_threshold;
    logic [3:0] r_fast_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= tmad_pkg::GAIN_RESET;
            r_threshold <= tmad_pkg::THRESHOLD_RESET;
            r_fast_step <= tmad_pkg::FAST_STEP_RESET;
        end else if (i_cfg_we) begin
            case (tmad_pkg::t_cfg_idx'(i_cfg_idx))
                tmad_pkg::CFG_MOTION_GAIN:    r_gain      <= i_cfg_data[3:0];
                tmad_pkg::CFG_FAST_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                tmad_pkg::CFG_FAST_STEP:      r_fast_step <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    tmad_pkg::t_axis_cfg w_axis_cfg;
    assign w_axis_cfg.gain      = r_gain;
    assign w_axis_cfg.threshold = r_threshold;
    assign w_axis_cfg.fast_step = r_fast_step;

    // input register
    logic            r_in_valid;
    tmad_pkg::t_mode r_in_mode;
    logic            r_in_begin;
    logic [7:0]      r_in_x;
    logic [7:0]      r_in_y;
    logic            r_in_button;

    // output register
    logic       r_out_valid;
    logic [3:0] r_right, r_left, r_down, r_up;
    logic [7:0] r_switch;

    logic w_out_free;
    logic w_proc;
    logic w_in_fire;
    logic w_touch_en;
    logic w_read_en;

    // output slot is free if empty or being taken this cycle
    assign w_out_free = !r_out_valid || o_out.ready;
    // touch samples never wait; reads wait for the output slot
    assign w_proc     = r_in_valid &&
                        ((r_in_mode == tmad_pkg::MODE_TOUCH) || w_out_free);
    assign w_touch_en = w_proc && (r_in_mode == tmad_pkg::MODE_TOUCH);
    assign w_read_en  = w_proc && (r_in_mode == tmad_pkg::MODE_READ);

    assign i_in.ready = !r_in_valid || w_proc;
    assign w_in_fire  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_mode   <= tmad_pkg::t_mode'(i_in.mode);
            r_in_begin  <= i_in.touch_start;
            r_in_x      <= i_in.x_pos;
            r_in_y      <= i_in.y_pos;
            r_in_button <= i_in.button_pressed;
        end
    end

    // position tracking and button state
    tmad_pkg::t_move w_move;
    logic            w_button_held;

    tmad_track u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_touch_en       (w_touch_en),
        .i_touch_start    (r_in_begin),
        .i_x_pos          (r_in_x),
        .i_y_pos          (r_in_y),
        .i_button_pressed (r_in_button),
        .o_move           (w_move),
        .o_button_held    (w_button_held)
    );

    // per-axis counters
    logic [3:0] w_right, w_left, w_down, w_up;

    tmad_axis u_axis_x (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_axis_cfg),
        .i_move_en    (w_move.move),
        .i_delta      (w_move.dx),
        .i_read_en    (w_read_en),
        .o_plus_step  (w_right),
        .o_minus_step (w_left)
    );

    tmad_axis u_axis_y (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_axis_cfg),
        .i_move_en    (w_move.move),
        .i_delta      (w_move.dy),
        .i_read_en    (w_read_en),
        .o_plus_step  (w_down),
        .o_minus_step (w_up)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_read_en) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read_en) begin
            r_right  <= w_right;
            r_left   <= w_left;
            r_down   <= w_down;
            r_up     <= w_up;
            r_switch <= w_button_held ? tmad_pkg::SWITCH_ON : tmad_pkg::SWITCH_OFF;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.right_step  = r_right;
    assign o_out.left_step   = r_left;
    assign o_out.down_step   = r_down;
    assign o_out.up_step     = r_up;
    assign o_out.switch_byte = r_switch;

    // a processed read always lands in the output register
    a_read_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_read_en |=> r_out_valid)
        else $error("read did not produce a result");

    // output appears only from a read
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !w_read_en) |=> !r_out_valid)
        else $error("result without a read");

    // a held item is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_proc) |-> !w_in_fire)
        else $error("input register overwritten");

    // a stalled result is not replaced by a new read
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_read_en)
        else $error("pending result replaced");

endmodule
